// File: rtl/core/trd_pkg.sv
// Package for the TLV request deframer: byte kinds, phase encoding and
// the per-byte result record. No dependencies.
`timescale 1ns / 1ps

package trd_pkg;

   // Records a frame may hold before the rest of it is dropped
   localparam int unsigned MAX_RECORDS = 8;
   localparam int unsigned REC_CNT_W   = $clog2(MAX_RECORDS + 1);

   // Byte kind codes reported with every byte
   localparam logic [2:0] KIND_INFO    = 3'd0;
   localparam logic [2:0] KIND_BLEN_HI = 3'd1;
   localparam logic [2:0] KIND_BLEN_LO = 3'd2;
   localparam logic [2:0] KIND_TYPE    = 3'd3;
   localparam logic [2:0] KIND_LEN_HI  = 3'd4;
   localparam logic [2:0] KIND_LEN_LO  = 3'd5;
   localparam logic [2:0] KIND_DATA    = 3'd6;
   localparam logic [2:0] KIND_DISCARD = 3'd7;

   // Error codes
   localparam logic ERR_NONE        = 1'b0;
   localparam logic ERR_TOO_MANY    = 1'b1;

   // Role of the next byte, one-hot
   typedef enum logic [7:0] {
      PH_INFO    = 8'b0000_0001,
      PH_BLEN_HI = 8'b0000_0010,
      PH_BLEN_LO = 8'b0000_0100,
      PH_TYPE    = 8'b0000_1000,
      PH_LEN_HI  = 8'b0001_0000,
      PH_LEN_LO  = 8'b0010_0000,
      PH_DATA    = 8'b0100_0000,
      PH_DISCARD = 8'b1000_0000
   } phase_type;

   // Labels for one byte
   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  byte_value;
      logic [7:0]  frame_info;
      logic [2:0]  record_index;
      logic [7:0]  record_kind;
      logic [15:0] record_length;
      logic [15:0] data_offset;
      logic        last_of_record;
      logic        last_of_frame;
      logic        error_code;
   } result_type;

endpackage

// File: rtl/core/trd_parser.sv
// Frame parser for the TLV request deframer: holds the frame and record
// state and labels one byte per transfer. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         in_byte,
   input  logic               frame_restart,
   output trd_pkg::result_type result
);
   import trd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [7:0]             frame_info_ff, frame_info_in;
   logic [15:0]            body_length_ff, body_length_in;
   logic [16:0]            consumed_ff, consumed_in;
   logic [REC_CNT_W-1:0]   rec_count_ff, rec_count_in;
   logic [7:0]             cur_type_ff, cur_type_in;
   logic [15:0]            cur_length_ff, cur_length_in;
   logic [15:0]            data_count_ff, data_count_in;

   phase_type              ph;
   logic                   close;
   logic                   err;
   logic                   last_frame;
   logic [2:0]             kind;
   logic [15:0]            offset;
   logic [15:0]            data_next;
   logic [17:0]            sum;
   logic [REC_CNT_W:0]     rec_next;

   // Decode the byte and compute the next state
   always_comb begin
      ph             = frame_restart ? PH_INFO : phase_ff;
      phase_in       = ph;
      frame_info_in  = frame_info_ff;
      body_length_in = body_length_ff;
      consumed_in    = consumed_ff;
      rec_count_in   = rec_count_ff;
      cur_type_in    = cur_type_ff;
      cur_length_in  = cur_length_ff;
      data_count_in  = data_count_ff;
      close          = 1'b0;
      err            = 1'b0;
      last_frame     = 1'b0;
      kind           = KIND_DISCARD;
      offset         = 16'd0;
      data_next      = data_count_ff + 16'd1;
      case (ph)
         PH_INFO: begin
            kind           = KIND_INFO;
            frame_info_in  = in_byte;
            body_length_in = 16'd0;
            consumed_in    = 17'd0;
            rec_count_in   = '0;
            cur_type_in    = 8'd0;
            cur_length_in  = 16'd0;
            data_count_in  = 16'd0;
            phase_in       = PH_BLEN_HI;
         end
         PH_BLEN_HI: begin
            kind           = KIND_BLEN_HI;
            body_length_in = {in_byte, 8'd0};
            phase_in       = PH_BLEN_LO;
         end
         PH_BLEN_LO: begin
            kind           = KIND_BLEN_LO;
            body_length_in = {body_length_ff[15:8], in_byte};
            if ({body_length_ff[15:8], in_byte} == 16'd0) begin
               last_frame = 1'b1;
               phase_in   = PH_INFO;
            end else begin
               phase_in   = PH_TYPE;
            end
         end
         PH_TYPE: begin
            kind          = KIND_TYPE;
            cur_type_in   = in_byte;
            cur_length_in = 16'd0;
            data_count_in = 16'd0;
            phase_in      = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            kind          = KIND_LEN_HI;
            cur_length_in = {in_byte, 8'd0};
            phase_in      = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            kind          = KIND_LEN_LO;
            cur_length_in = {cur_length_ff[15:8], in_byte};
            if ({cur_length_ff[15:8], in_byte} == 16'd0) begin
               close = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            kind          = KIND_DATA;
            offset        = data_count_ff;
            data_count_in = data_next;
            close         = (data_next == cur_length_ff);
         end
         default: begin
            kind = KIND_DISCARD;
            err  = 1'b1;
         end
      endcase

      // Close the record: end the frame, move to the next record or drop the rest
      sum      = {1'b0, consumed_ff} + 18'd3 + {2'b00, cur_length_in};
      rec_next = {1'b0, rec_count_ff} + (REC_CNT_W+1)'(1);
      if (close) begin
         if (sum >= {2'b00, body_length_in}) begin
            last_frame = 1'b1;
            phase_in   = PH_INFO;
         end else begin
            consumed_in = sum[16:0];
            if (rec_next >= (REC_CNT_W+1)'(MAX_RECORDS)) begin
               phase_in = PH_DISCARD;
            end else begin
               rec_count_in = rec_next[REC_CNT_W-1:0];
               phase_in     = PH_TYPE;
            end
         end
      end

      // Labels for this byte; an info byte starts at record zero
      result.byte_kind      = kind;
      result.byte_value     = in_byte;
      result.frame_info     = frame_info_in;
      result.record_index   = (err || ph == PH_INFO) ? 3'd0 : 3'(rec_count_ff);
      result.record_kind    = err ? 8'd0 : cur_type_in;
      result.record_length  = err ? 16'd0 : cur_length_in;
      result.data_offset    = offset;
      result.last_of_record = close;
      result.last_of_frame  = last_frame;
      result.error_code     = err ? ERR_TOO_MANY : ERR_NONE;
   end

   // Advance the state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_INFO;
         frame_info_ff  <= 8'd0;
         body_length_ff <= 16'd0;
         consumed_ff    <= 17'd0;
         rec_count_ff   <= '0;
         cur_type_ff    <= 8'd0;
         cur_length_ff  <= 16'd0;
         data_count_ff  <= 16'd0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         frame_info_ff  <= frame_info_in;
         body_length_ff <= body_length_in;
         consumed_ff    <= consumed_in;
         rec_count_ff   <= rec_count_in;
         cur_type_ff    <= cur_type_in;
         cur_length_ff  <= cur_length_in;
         data_count_ff  <= data_count_in;
      end
   end

endmodule

// File: rtl/core/tlv_request_deframer.sv
// TLV request deframer: usage notes below.
// Top level; depends on trd_pkg and trd_parser.
// ---------------------------------------------------------------------------
// Takes a request stream one byte per transfer on the req_ channel and gives
// one labelled byte per transfer on the rsp_ channel. A frame is an info
// byte, a big-endian 16-bit body length, then records of type byte,
// big-endian 16-bit length and data. req_tuser high marks the byte as the
// info byte of a new frame, abandoning any frame in progress.
// Each byte is reported with its kind, the frame info byte, the record index,
// type and length, its offset in the record, and record/frame end marks
// (frame end on rsp_tlast). After the eighth record of a frame, a further
// record is refused: every byte is reported as discarded with the error flag
// until a restart.
// A byte passes from an input register to a result register, with the parse
// logic between them. The deframer takes one byte per cycle while the
// receiver does not stall, and the parser updates its state on each transfer.
// When the receiver stalls, the result register holds and the input register
// fills; req_tready drops only when both are full.
// Reset clears the pipeline and returns the parser to expect an info byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlv_request_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] frame_restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] byte_value, [15:8] frame_info,
                                    // [18:16] record_index, [26:19] record_kind,
                                    // [42:27] record_length, [58:43] data_offset,
                                    // [59] last_of_record, [63:60] zero
   output logic [3:0]  rsp_tuser,   // [2:0] byte_kind, [3] error_code
   output logic        rsp_tlast    // last_of_frame
);
   import trd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_restart_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  parsed;
   logic        advance;

   // Move a byte from the input register into the result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Hold the input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser;
      end
   end

   trd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .in_byte       (in_byte_ff),
      .frame_restart (in_restart_ff),
      .result        (parsed)
   );

   // Result register: load on advance, drop on transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= parsed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0,
                        out_ff.last_of_record,
                        out_ff.data_offset,
                        out_ff.record_length,
                        out_ff.record_kind,
                        out_ff.record_index,
                        out_ff.frame_info,
                        out_ff.byte_value};
   assign rsp_tuser  = {out_ff.error_code, out_ff.byte_kind};
   assign rsp_tlast  = out_ff.last_of_frame;

endmodule
